// ===== rtl/core/ir_pulse_code_decoder_assert.svh =====
// Assertion macros used by the IR pulse-code decoder checker.
`ifndef IR_PULSE_CODE_DECODER_ASSERT_SVH
`define IR_PULSE_CODE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define IRPCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irpcd assertion failed");

// Next-cycle implication.
`define IRPCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irpcd assertion failed");

`endif

// ===== rtl/core/ir_pcd_pkg.sv =====
// Types, constants and register codes for the IR pulse-code decoder.
package ir_pcd_pkg;

  localparam int unsigned IntervalW = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] REG_LEAD_MIN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ONE_MIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ONE_MAX  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ZERO_MIN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ZERO_MAX = 3'd4;

  localparam logic [IntervalW-1:0] LEAD_MIN_RST = 16'd2500;
  localparam logic [IntervalW-1:0] ONE_MIN_RST  = 16'd2000;
  localparam logic [IntervalW-1:0] ONE_MAX_RST  = 16'd2500;
  localparam logic [IntervalW-1:0] ZERO_MIN_RST = 16'd1100;
  localparam logic [IntervalW-1:0] ZERO_MAX_RST = 16'd1150;

  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_STARTED = 2'd1;
  localparam logic [1:0] PHASE_LEAD    = 2'd2;
  localparam logic [1:0] PHASE_BITS    = 2'd3;

  localparam logic EV_CAPTURE = 1'b0;
  localparam logic EV_TIMEOUT = 1'b1;

  localparam logic EDGE_FALLING = 1'b0;
  localparam logic EDGE_RISING  = 1'b1;

  localparam logic [ByteW-1:0] BYTE_ONES = 8'hFF;

  typedef struct packed {
    logic                 event_kind;
    logic [IntervalW-1:0] interval;
  } ir_pcd_in_t;

  typedef struct packed {
    logic             edge_rising;
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] command;
    logic             code_valid;
  } ir_pcd_out_t;

  typedef struct packed {
    logic [IntervalW-1:0] lead_min;
    logic [IntervalW-1:0] one_min;
    logic [IntervalW-1:0] one_max;
    logic [IntervalW-1:0] zero_min;
    logic [IntervalW-1:0] zero_max;
  } ir_pcd_cfg_t;

  typedef struct packed {
    logic [1:0]           phase;
    logic [2*ByteW-1:0]   bit_shift;
    logic [ByteW-1:0]     addr_byte;
    logic [ByteW-1:0]     cmd_byte;
    logic                 edge_select;
  } ir_pcd_state_t;

endpackage

// ===== rtl/core/ir_pcd_step.sv =====
// Next-state logic of the decoder for one event.
module ir_pcd_step import ir_pcd_pkg::*; (
  input  ir_pcd_state_t cur_i,
  input  ir_pcd_in_t    item_i,
  input  ir_pcd_cfg_t   cfg_i,
  output ir_pcd_state_t nxt_o
);

  logic               is_one;
  logic               is_zero;
  logic [2*ByteW-1:0] sh;

  assign is_one  = (item_i.interval > cfg_i.one_min) && (item_i.interval < cfg_i.one_max);
  assign is_zero = (item_i.interval > cfg_i.zero_min) && (item_i.interval < cfg_i.zero_max);

  always_comb begin
    nxt_o = cur_i;
    sh    = cur_i.bit_shift;
    if (item_i.event_kind == EV_TIMEOUT) begin
      if (cur_i.phase != PHASE_IDLE) begin
        nxt_o.phase       = PHASE_IDLE;
        nxt_o.edge_select = EDGE_FALLING;
      end
    end else if (cur_i.phase == PHASE_IDLE) begin
      nxt_o.phase       = PHASE_STARTED;
      nxt_o.addr_byte   = '0;
      nxt_o.cmd_byte    = '0;
      nxt_o.bit_shift   = '0;
      nxt_o.edge_select = EDGE_RISING;
    end else begin
      if ((item_i.interval > cfg_i.lead_min) && (cur_i.phase == PHASE_STARTED)) begin
        nxt_o.phase = PHASE_LEAD;
      end
      if (is_one || is_zero) begin
        // first bit of a run is not shifted
        if (cur_i.phase != PHASE_BITS) begin
          nxt_o.phase = PHASE_BITS;
        end else begin
          sh = {cur_i.bit_shift[2*ByteW-2:0], 1'b0};
        end
        sh[0] = sh[0] | is_one;
        nxt_o.bit_shift = sh;
        if ((sh[2*ByteW-1:ByteW] ^ sh[ByteW-1:0]) == BYTE_ONES) begin
          if (cur_i.addr_byte == '0) begin
            nxt_o.addr_byte = sh[2*ByteW-1:ByteW];
            nxt_o.bit_shift = '0;
            nxt_o.phase     = PHASE_LEAD;
          end else begin
            nxt_o.cmd_byte = sh[2*ByteW-1:ByteW];
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/ir_pulse_code_decoder.sv =====
// Top level of the IR pulse-code decoder: config registers, state and result stage.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | ir_pcd_in_t  (event_kind, interval)
//  out     | output    | out_valid_o/out_ready_i | ir_pcd_out_t (edge_rising, address,
//          |           |                         |   command, code_valid)
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One event per cycle while in_ready_o is high; its registered result is shown in the cycle after acceptance.
// State update and result are one compare/shift stage ahead of the result register.
// in_ready_o is high when the result register is empty or is being taken.
// Reset loads the register defaults and returns the decoder to idle, falling edge.
module ir_pulse_code_decoder import ir_pcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ir_pcd_in_t          in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ir_pcd_out_t         out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  ir_pcd_cfg_t   cfg_q;
  ir_pcd_state_t state_q;
  ir_pcd_state_t state_d;
  logic          out_valid_q;
  ir_pcd_out_t   out_item_q;
  logic          in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lead_min <= LEAD_MIN_RST;
      cfg_q.one_min  <= ONE_MIN_RST;
      cfg_q.one_max  <= ONE_MAX_RST;
      cfg_q.zero_min <= ZERO_MIN_RST;
      cfg_q.zero_max <= ZERO_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEAD_MIN: cfg_q.lead_min <= cfg_wdata_i;
        REG_ONE_MIN:  cfg_q.one_min  <= cfg_wdata_i;
        REG_ONE_MAX:  cfg_q.one_max  <= cfg_wdata_i;
        REG_ZERO_MIN: cfg_q.zero_min <= cfg_wdata_i;
        REG_ZERO_MAX: cfg_q.zero_max <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ir_pcd_step u_step (
    .cur_i  (state_q),
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .nxt_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_item_q.edge_rising <= state_d.edge_select;
      out_item_q.address     <= state_d.addr_byte;
      out_item_q.command     <= state_d.cmd_byte;
      out_item_q.code_valid  <= (state_d.addr_byte != '0) && (state_d.cmd_byte != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/ir_pcd_checker.sv =====
// Port-level checker for the IR pulse-code decoder, bound to the top level.
`include "ir_pulse_code_decoder_assert.svh"

module ir_pcd_checker import ir_pcd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ir_pcd_in_t          in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ir_pcd_out_t         out_item_o,
  input logic                cfg_we_i,
  input logic [CfgIdxW-1:0]  cfg_idx_i,
  input logic [CfgDataW-1:0] cfg_wdata_i
);

  logic in_fire;
  logic timeout_fire;
  logic cfg_seen;

  assign in_fire      = in_valid_i && in_ready_o;
  assign timeout_fire = in_fire && (in_item_i.event_kind == EV_TIMEOUT);
  assign cfg_seen     = cfg_we_i && (cfg_idx_i <= REG_ZERO_MAX) && (cfg_wdata_i != '1);

  `IRPCD_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, in_fire, out_valid_o)
  `IRPCD_ASSERT_NEXT(a_timeout_falling, clk_i, rst_ni, timeout_fire,
                     out_item_o.edge_rising == EDGE_FALLING)
  `IRPCD_ASSERT_NOW(a_valid_code_bytes, clk_i, rst_ni, out_valid_o && out_item_o.code_valid,
                    (out_item_o.address != '0) && (out_item_o.command != '0))
  `IRPCD_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_o || cfg_seen, in_ready_o || out_valid_o)

endmodule

bind ir_pulse_code_decoder ir_pcd_checker u_ir_pcd_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the IR pulse-code decoder: directed and random frame traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ir_pcd_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  ir_pcd_in_t          in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  ir_pcd_out_t         out_item_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ir_pulse_code_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // decoder shadow state
  ir_pcd_cfg_t      dec_cfg;
  logic [1:0]       dec_phase;
  logic [15:0]      dec_shift;
  logic [ByteW-1:0] dec_addr;
  logic [ByteW-1:0] dec_cmd;
  logic             dec_edge;

  ir_pcd_out_t expected_codes[$];
  bit          pace_on = 1'b1;
  int          fail_count;
  int          items_sent;
  int          results_seen;
  int          frames_sent;
  int          config_loads;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic ir_pcd_out_t decode_event(ir_pcd_in_t ev);
    logic             is_one;
    logic             is_zero;
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    ir_pcd_out_t      res;
    if (ev.event_kind == EV_TIMEOUT) begin
      if (dec_phase != PHASE_IDLE) begin
        dec_phase = PHASE_IDLE;
        dec_edge  = EDGE_FALLING;
      end
    end else if (dec_phase == PHASE_IDLE) begin
      dec_phase = PHASE_STARTED;
      dec_addr  = '0;
      dec_cmd   = '0;
      dec_shift = '0;
      dec_edge  = EDGE_RISING;
    end else begin
      if (ev.interval > dec_cfg.lead_min && dec_phase == PHASE_STARTED) dec_phase = PHASE_LEAD;
      is_one  = (ev.interval > dec_cfg.one_min) && (ev.interval < dec_cfg.one_max);
      is_zero = (ev.interval > dec_cfg.zero_min) && (ev.interval < dec_cfg.zero_max);
      if (is_one || is_zero) begin
        if (dec_phase != PHASE_BITS) dec_phase = PHASE_BITS;
        else dec_shift = dec_shift << 1;
        if (is_one) dec_shift[0] = 1'b1;
        hi = dec_shift[15:8];
        lo = dec_shift[7:0];
        if ((hi ^ lo) == BYTE_ONES) begin
          if (dec_addr == '0) begin
            dec_addr  = hi;
            dec_shift = '0;
            dec_phase = PHASE_LEAD;
          end else begin
            dec_cmd = hi;
          end
        end
      end
    end
    res.edge_rising = dec_edge;
    res.address     = dec_addr;
    res.command     = dec_cmd;
    res.code_valid  = (dec_addr != '0) && (dec_cmd != '0);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!pace_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IntervalW-1:0] pick_between(logic [IntervalW-1:0] lo,
                                                        logic [IntervalW-1:0] hi);
    if (int'(hi) - int'(lo) >= 2) return IntervalW'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    return IntervalW'($urandom);
  endfunction

  function automatic logic [IntervalW-1:0] pick_lead();
    if (dec_cfg.lead_min != '1) return IntervalW'($urandom_range(int'(dec_cfg.lead_min) + 1, 65535));
    return IntervalW'($urandom);
  endfunction

  task automatic flag_result(string why, ir_pcd_out_t want, ir_pcd_out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%t mismatch (%s): exp edge=%0b addr=%02h cmd=%02h vld=%0b, got edge=%0b addr=%02h cmd=%02h vld=%0b",
               $realtime, why, want.edge_rising, want.address, want.command, want.code_valid,
               got.edge_rising, got.address, got.command, got.code_valid);
  endtask

  // A transaction on the result side completes at the edge after this sample.
  initial begin : result_checker
    ir_pcd_out_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_codes.size() == 0) begin
          flag_result("no result pending", '0, out_item_o);
        end else begin
          want = expected_codes.pop_front();
          if (out_item_o.edge_rising !== want.edge_rising || out_item_o.address !== want.address ||
              out_item_o.command !== want.command || out_item_o.code_valid !== want.code_valid)
            flag_result("field", want, out_item_o);
        end
      end
    end
  end

  initial begin : sink_pacing
    int   hold;
    logic rdy;
    hold = 0;
    rdy  = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!pace_on) begin
        rdy = 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        rdy  = ~rdy;
        hold = rdy ? $urandom_range(0, 8) : pick_gap();
      end
      out_ready_i <= rdy;
    end
  end

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_event(input logic kind, input logic [IntervalW-1:0] ivl);
    ir_pcd_in_t ev;
    int         gap;
    ev.event_kind = kind;
    ev.interval   = ivl;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= ev;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    expected_codes.push_back(decode_event(ev));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic load_windows(input logic [IntervalW-1:0] lead, omin, omax, zmin, zmax);
    logic [CfgIdxW-1:0]  idx_list[6];
    logic [CfgDataW-1:0] val_list[6];
    idx_list = '{REG_LEAD_MIN, REG_ONE_MIN, REG_ONE_MAX, REG_ZERO_MIN, REG_ZERO_MAX,
                 CfgIdxW'($urandom_range(int'(REG_ZERO_MAX) + 1, (1 << CfgIdxW) - 1))};
    val_list = '{lead, omin, omax, zmin, zmax, CfgDataW'($urandom)};
    for (int k = 0; k < 6; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx_list[k];
      cfg_wdata_i <= val_list[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    dec_cfg.lead_min = lead;
    dec_cfg.one_min  = omin;
    dec_cfg.one_max  = omax;
    dec_cfg.zero_min = zmin;
    dec_cfg.zero_max = zmax;
    config_loads++;
  endtask

  // Timeout, start, lead, address, ~address, command, ~command; sloppy frames add faults.
  task automatic send_frame(input bit sloppy);
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] c;
    logic [31:0]      bits;
    a = ($urandom_range(0, 7) == 0) ? ByteW'($urandom) : ByteW'($urandom_range(1, 254));
    c = ($urandom_range(0, 7) == 0) ? ByteW'($urandom) : ByteW'($urandom_range(1, 254));
    bits = {a, ~a, c, ~c};
    send_event(EV_TIMEOUT, IntervalW'($urandom));
    send_event(EV_CAPTURE, IntervalW'($urandom));
    send_event(EV_CAPTURE, pick_lead());
    for (int n = 31; n >= 0; n--) begin
      if (sloppy && $urandom_range(0, 15) == 0) send_event(EV_CAPTURE, IntervalW'($urandom));
      if (sloppy && $urandom_range(0, 31) == 0) bits[n] = ~bits[n];
      if (sloppy && $urandom_range(0, 63) == 0) break;
      send_event(EV_CAPTURE, bits[n] ? pick_between(dec_cfg.one_min, dec_cfg.one_max)
                                     : pick_between(dec_cfg.zero_min, dec_cfg.zero_max));
    end
    if ($urandom_range(0, 1)) send_event(EV_TIMEOUT, IntervalW'($urandom));
    frames_sent++;
  endtask

  task automatic send_noise(input int count);
    logic [IntervalW-1:0] ivl;
    int                   r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 9);
      if (r < 2) ivl = pick_between(dec_cfg.one_min, dec_cfg.one_max);
      else if (r < 4) ivl = pick_between(dec_cfg.zero_min, dec_cfg.zero_max);
      else ivl = IntervalW'($urandom);
      send_event(($urandom_range(0, 3) == 0) ? EV_TIMEOUT : EV_CAPTURE, ivl);
    end
  endtask

  task automatic test_reset_defaults();
    send_event(EV_TIMEOUT, 16'hFFFF);
    send_event(EV_CAPTURE, 16'h0000);
    send_event(EV_CAPTURE, 16'hFFFF);
    send_event(EV_CAPTURE, 16'd2500);
    send_event(EV_CAPTURE, 16'd2000);
    send_event(EV_CAPTURE, 16'd1100);
    send_event(EV_CAPTURE, 16'd1150);
    send_event(EV_CAPTURE, 16'd2001);
    send_event(EV_CAPTURE, 16'd1149);
    send_event(EV_CAPTURE, 16'd2499);
    send_event(EV_TIMEOUT, 16'h0000);
    send_event(EV_TIMEOUT, 16'h5A5A);
    send_event(EV_CAPTURE, 16'd2501);
    send_event(EV_CAPTURE, 16'd2501);
    // eight ones give 00/FF: address taken as zero
    for (int k = 0; k < 8; k++) send_event(EV_CAPTURE, 16'd2200);
    send_event(EV_CAPTURE, 16'd1101);
    send_event(EV_TIMEOUT, 16'hA5A5);
    drain_results();
  endtask

  task automatic test_overlapping_windows();
    load_windows(16'd3000, 16'd1000, 16'd2000, 16'd1400, 16'd1600);
    send_event(EV_TIMEOUT, 16'd0);
    send_event(EV_CAPTURE, 16'd1500);
    send_event(EV_CAPTURE, 16'd4000);
    for (int k = 0; k < 8; k++) send_event(EV_CAPTURE, 16'd1500);
    send_frame(1'b0);
    drain_results();
  endtask

  task automatic test_extreme_settings();
    load_windows('0, '0, '0, '0, '0);
    send_event(EV_CAPTURE, 16'd0);
    send_event(EV_CAPTURE, 16'd0);
    send_event(EV_CAPTURE, 16'd1);
    send_noise(8);
    send_frame(1'b0);
    drain_results();
    load_windows('1, '1, '1, '1, '1);
    send_event(EV_TIMEOUT, 16'd0);
    send_event(EV_CAPTURE, 16'hFFFF);
    send_event(EV_CAPTURE, 16'hFFFF);
    send_event(EV_CAPTURE, 16'hFFFE);
    send_noise(8);
    drain_results();
    load_windows('1, '0, '1, '0, '1);
    send_noise(20);
    send_frame(1'b0);
    drain_results();
    load_windows(16'd0, '1, '0, '0, '1);
    send_noise(12);
    send_frame(1'b0);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int zlo, zhi, olo, ohi, ld, start, r;
    bit paused;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        load_windows(LEAD_MIN_RST, ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST);
      end else begin
        zlo = $urandom_range(0, 30000);
        zhi = zlo + $urandom_range(2, 3000);
        olo = ($urandom_range(0, 4) == 0) ? zlo + $urandom_range(0, 1000)
                                          : zhi + $urandom_range(0, 5000);
        ohi = olo + $urandom_range(2, 4000);
        ld  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, ohi) : $urandom_range(ohi, 65535);
        load_windows(IntervalW'(ld), IntervalW'(olo), IntervalW'(ohi), IntervalW'(zlo),
                     IntervalW'(zhi));
      end
      pace_on = (ph != 2);
      start   = items_sent;
      paused  = 1'b0;
      while (items_sent - start < 50) begin
        r = $urandom_range(0, 9);
        if (r < 6) send_frame(1'b0);
        else if (r < 8) send_frame(1'b1);
        else send_noise($urandom_range(1, 12));
        if (!paused && items_sent - start >= 25) begin
          drain_results();
          paused = 1'b1;
        end
      end
      drain_results();
    end
    pace_on = 1'b1;
  endtask

  initial begin : stimulus
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    dec_cfg.lead_min = LEAD_MIN_RST;
    dec_cfg.one_min  = ONE_MIN_RST;
    dec_cfg.one_max  = ONE_MAX_RST;
    dec_cfg.zero_min = ZERO_MIN_RST;
    dec_cfg.zero_max = ZERO_MAX_RST;
    dec_phase = PHASE_IDLE;
    dec_shift = '0;
    dec_addr  = '0;
    dec_cmd   = '0;
    dec_edge  = EDGE_FALLING;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_overlapping_windows();
    test_extreme_settings();
    test_random_traffic();

    drain_results();
    repeat (4) @(posedge clk_i);
    if (expected_codes.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", expected_codes.size());
    end
    $display("sent %0d events (%0d frames), checked %0d results, %0d mismatches",
             items_sent, frames_sent, results_seen, fail_count);
    $display("%0d window settings incl. reset defaults, empty, full and overlapping windows",
             config_loads);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ir_pcd_pkg.sv
rtl/core/ir_pcd_step.sv
rtl/core/ir_pulse_code_decoder.sv
rtl/core/ir_pcd_checker.sv
tb/tb_top.sv
